[rtl/core/grid_cell_polygon_classifier_assert.svh]
// assertion macros for the grid cell polygon classifier
`ifndef GRID_CELL_POLYGON_CLASSIFIER_ASSERT_SVH
`define GRID_CELL_POLYGON_CLASSIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GCPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcpc assertion failed");
`define GCPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcpc assertion failed");
`else
`define GCPC_ASSERT_IMPL(label, ante, cons)
`define GCPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/gcpc_pkg.sv]
// shared types and constants of the grid cell polygon classifier
`timescale 1ns / 1ps
package gcpc_pkg;

  localparam int COORD_W    = 16;
  localparam int COUNT_W    = 6;
  localparam int SLOT_W     = 5;
  localparam int CELL_W     = 6;
  localparam int SIZE_W     = 12;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // corner coordinates, operand and product widths of the shared multiplier
  localparam int PX_W   = 20;
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_INSIDE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MIXED   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OUTSIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ORIGIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ORIGIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd4;

  localparam logic [SIZE_W-1:0] CELL_WIDTH_RESET  = 12'd20;
  localparam logic [SIZE_W-1:0] CELL_HEIGHT_RESET = 12'd12;

endpackage

[rtl/core/gcpc_if.sv]
// request and result channel interfaces of the grid cell polygon classifier
`timescale 1ns / 1ps
interface gcpc_req_if import gcpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [SLOT_W-1:0]         vertex_slot;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic [CELL_W-1:0]         cell_row;
  logic [CELL_W-1:0]         cell_col;

  modport source (output valid, command, vertex_slot, vertex_x, vertex_y, cell_row,
                  cell_col, input ready);
  modport sink (input valid, command, vertex_slot, vertex_x, vertex_y, cell_row,
                cell_col, output ready);
endinterface

interface gcpc_rsp_if import gcpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] cell_class;

  modport source (output valid, cell_class, input ready);
  modport sink (input valid, cell_class, output ready);
endinterface

[rtl/core/grid_cell_polygon_classifier.sv]
// grid cell classifier: crossing-number test of four cell corners against a polygon
// a vertex write item is taken only while idle, goes into the vertex table and gives no result
// a classify item runs SETX, SETY, LOAD, then the edge steps for each of the n vertices in use,
// then DONE; no new item is taken until its result is loaded into the output register; one
// shared multiplier does 4 products per edge in steps MUL_Y0, MUL_Y1, MUL_X0, MUL_X1 and CLOSE
// reset: sync active high; resets control and config registers, vertex table undefined until written
`timescale 1ns / 1ps
`include "grid_cell_polygon_classifier_assert.svh"
module grid_cell_polygon_classifier import gcpc_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gcpc_req_if.sink              req,
  gcpc_rsp_if.source            rsp
);

  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SETX = 3'd1;
  localparam logic [2:0] S_SETY = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_EDGE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [2:0] E_MUL_Y0 = 3'd0;
  localparam logic [2:0] E_MUL_Y1 = 3'd1;
  localparam logic [2:0] E_MUL_X0 = 3'd2;
  localparam logic [2:0] E_MUL_X1 = 3'd3;
  localparam logic [2:0] E_CLOSE  = 3'd4;

  // configuration registers
  logic [COUNT_W-1:0]        vertex_count;
  logic signed [COORD_W-1:0] grid_origin_x;
  logic signed [COORD_W-1:0] grid_origin_y;
  logic [SIZE_W-1:0]         cell_width;
  logic [SIZE_W-1:0]         cell_height;

  // vertex table
  logic signed [COORD_W-1:0] poly_x_table [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y_table [MAX_VERTICES];
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;

  // sequencer
  logic [2:0]                state;
  logic [2:0]                step;
  logic [CNT_W-1:0]          n_cnt;
  logic [CNT_W-1:0]          n_eff;
  logic [CNT_W-1:0]          n_dec;
  logic [CNT_W-1:0]          edge_idx;
  logic [CNT_W-1:0]          edge_next;
  logic [CELL_W-1:0]         row;
  logic [CELL_W-1:0]         col;

  // edge endpoints: cur is vertex i, prev is vertex j
  logic signed [COORD_W-1:0] xi;
  logic signed [COORD_W-1:0] yi;
  logic signed [COORD_W-1:0] xj;
  logic signed [COORD_W-1:0] yj;

  logic signed [PX_W-1:0]    x0;
  logic signed [PX_W-1:0]    x1;
  logic signed [PX_W-1:0]    y0;
  logic signed [PX_W-1:0]    y1;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  rhs_lo;
  logic signed [PROD_W-1:0]  rhs_hi;
  logic                      cross_lo;
  logic                      cross_hi;
  logic                      dpos;
  logic                      hit_lo;
  logic                      hit_hi;
  logic [3:0]                corner_flags;

  logic                      out_valid;
  logic [CLASS_W-1:0]        out_class;
  logic [CLASS_W-1:0]        class_next;
  logic                      out_load;
  logic                      req_take;

  assign req.ready  = (state == S_IDLE) && !rst;
  assign req_take   = req.valid && req.ready;
  assign rsp.valid  = out_valid;
  assign rsp.cell_class = out_class;

  assign wr_en = req_take && (req.command == CMD_WRITE) &&
                 (32'(req.vertex_slot) < 32'(MAX_VERTICES));

  always_comb begin
    if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = CNT_W'(vertex_count);
    end
  end

  assign n_dec     = n_cnt - 1'b1;
  assign edge_next = edge_idx + 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      grid_origin_x <= '0;
      grid_origin_y <= '0;
      cell_width    <= CELL_WIDTH_RESET;
      cell_height   <= CELL_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data[COUNT_W-1:0];
        REG_GRID_ORIGIN_X: grid_origin_x <= cfg_data[COORD_W-1:0];
        REG_GRID_ORIGIN_Y: grid_origin_y <= cfg_data[COORD_W-1:0];
        REG_CELL_WIDTH:    cell_width    <= cfg_data[SIZE_W-1:0];
        REG_CELL_HEIGHT:   cell_height   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // table read: vertex n-1 in setup, vertex 0 next, then i+1 at the start of each edge
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_SETX: begin
        rd_en   = (n_cnt != '0);
        rd_addr = n_dec[AW-1:0];
      end
      S_SETY: begin
        rd_en   = (n_cnt != '0);
        rd_addr = '0;
      end
      S_EDGE: begin
        rd_en   = (step == E_MUL_Y0) && (edge_next < n_cnt);
        rd_addr = edge_next[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      poly_x_table[AW'(req.vertex_slot)] <= req.vertex_x;
      poly_y_table[AW'(req.vertex_slot)] <= req.vertex_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x <= poly_x_table[rd_addr];
      rd_y <= poly_y_table[rd_addr];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SETX: begin
        mul_a = MUL_A_W'(col);
        mul_b = MUL_B_W'(cell_width);
      end
      S_SETY: begin
        mul_a = MUL_A_W'(row);
        mul_b = MUL_B_W'(cell_height);
      end
      S_EDGE: begin
        case (step)
          E_MUL_Y0: begin
            mul_a = MUL_A_W'(y0) - MUL_A_W'(yi);
            mul_b = MUL_B_W'(xj) - MUL_B_W'(xi);
          end
          E_MUL_Y1: begin
            mul_a = MUL_A_W'(y1) - MUL_A_W'(yi);
            mul_b = MUL_B_W'(xj) - MUL_B_W'(xi);
          end
          E_MUL_X0: begin
            mul_a = MUL_A_W'(x0) - MUL_A_W'(xi);
            mul_b = MUL_B_W'(yj) - MUL_B_W'(yi);
          end
          E_MUL_X1: begin
            mul_a = MUL_A_W'(x1) - MUL_A_W'(xi);
            mul_b = MUL_B_W'(yj) - MUL_B_W'(yi);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // compare direction follows the sign of yj - yi
  assign hit_lo = dpos ? (prod <= rhs_lo) : (prod >= rhs_lo);
  assign hit_hi = dpos ? (prod <= rhs_hi) : (prod >= rhs_hi);

  always_comb begin
    if (corner_flags == 4'b1111) begin
      class_next = CLASS_INSIDE;
    end else if (corner_flags == 4'b0000) begin
      class_next = CLASS_OUTSIDE;
    end else begin
      class_next = CLASS_MIXED;
    end
  end

  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= E_MUL_Y0;
      edge_idx     <= '0;
      n_cnt        <= '0;
      corner_flags <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take && (req.command == CMD_CLASSIFY)) begin
            n_cnt <= n_eff;
            state <= S_SETX;
          end
        end
        S_SETX: state <= S_SETY;
        S_SETY: state <= S_LOAD;
        S_LOAD: begin
          edge_idx     <= '0;
          step         <= E_MUL_Y0;
          corner_flags <= '0;
          state        <= (n_cnt == '0) ? S_DONE : S_EDGE;
        end
        S_EDGE: begin
          case (step)
            E_MUL_Y0: step <= E_MUL_Y1;
            E_MUL_Y1: step <= E_MUL_X0;
            E_MUL_X0: step <= E_MUL_X1;
            E_MUL_X1: begin
              corner_flags[0] <= corner_flags[0] ^ (cross_lo & hit_lo);
              corner_flags[2] <= corner_flags[2] ^ (cross_hi & hit_hi);
              step            <= E_CLOSE;
            end
            E_CLOSE: begin
              corner_flags[1] <= corner_flags[1] ^ (cross_lo & hit_lo);
              corner_flags[3] <= corner_flags[3] ^ (cross_hi & hit_hi);
              step            <= E_MUL_Y0;
              edge_idx        <= edge_next;
              if (edge_next == n_cnt) begin
                state <= S_DONE;
              end
            end
            default: step <= E_MUL_Y0;
          endcase
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      row <= req.cell_row;
      col <= req.cell_col;
    end
    case (state)
      S_SETY: begin
        x0 <= PX_W'(grid_origin_x) + prod[PX_W-1:0];
        x1 <= PX_W'(grid_origin_x) + prod[PX_W-1:0] + PX_W'(cell_width);
        xj <= rd_x;
        yj <= rd_y;
      end
      S_LOAD: begin
        y0 <= PX_W'(grid_origin_y) + prod[PX_W-1:0];
        y1 <= PX_W'(grid_origin_y) + prod[PX_W-1:0] + PX_W'(cell_height);
        xi <= rd_x;
        yi <= rd_y;
      end
      S_EDGE: begin
        case (step)
          E_MUL_Y0: begin
            cross_lo <= (PX_W'(yi) >= y0) != (PX_W'(yj) >= y0);
            cross_hi <= (PX_W'(yi) >= y1) != (PX_W'(yj) >= y1);
            dpos     <= (yj > yi);
          end
          E_MUL_Y1: rhs_lo <= prod;
          E_MUL_X0: rhs_hi <= prod;
          E_CLOSE: begin
            // step to the next edge: vertex i becomes j
            xj <= xi;
            yj <= yi;
            xi <= rd_x;
            yi <= rd_y;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class <= class_next;
    end
  end

  `GCPC_ASSERT_IMPL(a_result_from_done, $rose(out_valid), $past(state) == S_DONE)
  `GCPC_ASSERT_IMPL(a_edge_in_range, state == S_EDGE, edge_idx < n_cnt)
  `GCPC_ASSERT_NEXT(a_write_stays_idle, req_take && (req.command == CMD_WRITE), state == S_IDLE)
  `GCPC_ASSERT_NEXT(a_done_waits, (state == S_DONE) && out_valid && !rsp.ready, state == S_DONE)

endmodule

[verif/cell_class_monitor.sv]
// watches the classifier channels, predicts each cell class and compares it with the block
`timescale 1ns / 1ps
module cell_class_monitor import gcpc_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gcpc_req_if                   req,
  gcpc_rsp_if                   rsp,
  output int                    fail_count,
  output int                    pending_classes
);

  logic signed [COORD_W-1:0] vert_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] vert_y [MAX_VERTICES];
  logic [COUNT_W-1:0]        vertex_count;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic [SIZE_W-1:0]         cell_w;
  logic [SIZE_W-1:0]         cell_h;
  logic [CLASS_W-1:0]        class_queue [$];
  logic [CLASS_W-1:0]        expected_class;

  // crossing-number test of one point against the closed polygon
  function automatic bit corner_in(longint px, longint py);
    int n, j;
    bit in_poly;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    in_poly = 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = longint'(vert_x[i]);
      yi = longint'(vert_y[i]);
      xj = longint'(vert_x[j]);
      yj = longint'(vert_y[j]);
      if ((yi >= py) != (yj >= py)) begin
        dy = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        // cross-multiplied compare flips with the sign of the edge's rise
        if (dy > 0 ? (lhs <= rhs) : (lhs >= rhs)) in_poly = !in_poly;
      end
      j = i;
    end
    return in_poly;
  endfunction

  function automatic logic [CLASS_W-1:0] predict_class(logic [CELL_W-1:0] row,
                                                       logic [CELL_W-1:0] col);
    longint r, c, w, h, x0, y0, x1, y1;
    bit [3:0] hits;
    r = longint'(row);
    c = longint'(col);
    w = longint'(cell_w);
    h = longint'(cell_h);
    x0 = longint'(origin_x) + c * w;
    y0 = longint'(origin_y) + r * h;
    x1 = x0 + w;
    y1 = y0 + h;
    hits = {corner_in(x1, y1), corner_in(x0, y1), corner_in(x1, y0), corner_in(x0, y0)};
    if (&hits) return CLASS_INSIDE;
    if (hits == 4'b0000) return CLASS_OUTSIDE;
    return CLASS_MIXED;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      vertex_count = '0;
      origin_x = '0;
      origin_y = '0;
      cell_w = CELL_WIDTH_RESET;
      cell_h = CELL_HEIGHT_RESET;
      class_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VERTEX_COUNT:  vertex_count = cfg_data[COUNT_W-1:0];
          REG_GRID_ORIGIN_X: origin_x = cfg_data[COORD_W-1:0];
          REG_GRID_ORIGIN_Y: origin_y = cfg_data[COORD_W-1:0];
          REG_CELL_WIDTH:    cell_w = cfg_data[SIZE_W-1:0];
          REG_CELL_HEIGHT:   cell_h = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      // a result at this edge can only belong to an item taken earlier
      if (rsp.valid && rsp.ready) begin
        if (class_queue.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: cell class %0d with no classify item waiting", $time,
                     rsp.cell_class);
          fail_count++;
        end else begin
          expected_class = class_queue.pop_front();
          if (rsp.cell_class !== expected_class) begin
            if (fail_count < 10)
              $display("%0t: cell_class expected %0d, got %0d", $time, expected_class,
                       rsp.cell_class);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.command == CMD_WRITE) begin
          if (req.vertex_slot < MAX_VERTICES) begin
            vert_x[req.vertex_slot] = req.vertex_x;
            vert_y[req.vertex_slot] = req.vertex_y;
          end
        end else begin
          class_queue = {class_queue, predict_class(req.cell_row, req.cell_col)};
        end
      end
    end
    pending_classes = class_queue.size();
  end

endmodule

[verif/testbench.sv]
// stimulus, handshake timing and verdict for the grid cell polygon classifier
`timescale 1ns / 1ps
module testbench;
  import gcpc_pkg::*;

  localparam int MAX_VERTICES    = 32;
  localparam int GRID_SIDE       = 64;
  localparam int TOTAL_ITEMS     = 1350;
  localparam int WRITE_SETTLE    = 4;
  localparam int DRAIN_CYCLES    = 200;
  localparam int RSP_HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT     = 3000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_classes;
  int                    items_sent;
  int                    send_quiet;
  int                    rsp_quiet;

  gcpc_req_if req ();
  gcpc_rsp_if rsp ();

  grid_cell_polygon_classifier #(.MAX_VERTICES(MAX_VERTICES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  cell_class_monitor #(.MAX_VERTICES(MAX_VERTICES)) i_monitor (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req             (req),
    .rsp             (rsp),
    .fail_count      (fail_count),
    .pending_classes (pending_classes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // mostly no gap, else mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int idle_gap(inout int quiet_left);
    int roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      quiet_left = $urandom_range(30, 200);
      return 0;
    end
    if ($urandom_range(0, 3) != 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // mostly near the grid, sometimes anywhere in the coordinate range
  function automatic int rand_coord(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535) - 32768;
    return lo + $urandom_range(0, hi - lo);
  endfunction

  // result side: random ready gaps plus one long hold once traffic is flowing
  initial begin : result_sink
    int gap_left;
    int taken;
    bit held;
    gap_left = 0;
    taken = 0;
    held = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) taken++;
      @(negedge clk);
      if (!held && taken >= 20) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
      end
      if (gap_left == 0) gap_left = idle_gap(rsp_quiet);
      if (gap_left > 0) begin
        rsp.ready <= 1'b0;
        gap_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic command, input logic [SLOT_W-1:0] slot,
                           input logic signed [COORD_W-1:0] vx,
                           input logic signed [COORD_W-1:0] vy,
                           input logic [CELL_W-1:0] row, input logic [CELL_W-1:0] col);
    int gap;
    gap = idle_gap(send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.command <= command;
    req.vertex_slot <= slot;
    req.vertex_x <= vx;
    req.vertex_y <= vy;
    req.cell_row <= row;
    req.cell_col <= col;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  task automatic write_vertex(input int slot, input int vx, input int vy);
    send_item(CMD_WRITE, slot[SLOT_W-1:0], vx[COORD_W-1:0], vy[COORD_W-1:0],
              CELL_W'($urandom()), CELL_W'($urandom()));
  endtask

  task automatic classify_at(input int row, input int col);
    send_item(CMD_CLASSIFY, SLOT_W'($urandom()), COORD_W'($urandom()),
              COORD_W'($urandom()), row[CELL_W-1:0], col[CELL_W-1:0]);
  endtask

  // drop valid, let every classify come back and the last vertex write land
  task automatic wait_idle();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_classes != 0) @(negedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int count, input int ox, input int oy, input int w,
                            input int h);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(count));
    write_reg(REG_GRID_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_GRID_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_CELL_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_CELL_HEIGHT, CFG_DATA_W'(h));
  endtask

  // new geometry, a full polygon over the grid area, then a burst of mostly classifies
  task automatic run_phase(input int phase_no);
    int count, ox, oy, w, h, n, roll, burst;
    int lo_x, hi_x, lo_y, hi_y;
    roll = $urandom_range(0, 99);
    if (phase_no == 0) count = 63;
    else if (phase_no == 1) count = MAX_VERTICES;
    else if (phase_no == 2) count = 3;
    else if (roll < 10) count = $urandom_range(0, 2);
    else if (roll < 70) count = $urandom_range(3, 12);
    else if (roll < 90) count = $urandom_range(13, MAX_VERTICES);
    else count = $urandom_range(MAX_VERTICES + 1, 63);
    if (phase_no == 0) begin
      ox = -32768;
      oy = -32768;
      w = 4095;
      h = 4095;
    end else if (phase_no == 1) begin
      ox = 32767;
      oy = 32767;
      w = 1;
      h = 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 10) ox = $urandom_range(0, 1) ? 32767 : -32768;
      else if (roll < 30) ox = $urandom_range(0, 65535) - 32768;
      else ox = $urandom_range(0, 4000) - 2000;
      roll = $urandom_range(0, 99);
      if (roll < 10) oy = $urandom_range(0, 1) ? 32767 : -32768;
      else if (roll < 30) oy = $urandom_range(0, 65535) - 32768;
      else oy = $urandom_range(0, 4000) - 2000;
      roll = $urandom_range(0, 99);
      if (roll < 8) w = 0;
      else if (roll < 15) w = 4095;
      else if (roll < 30) w = $urandom_range(0, 4095);
      else w = $urandom_range(1, 100);
      roll = $urandom_range(0, 99);
      if (roll < 8) h = 0;
      else if (roll < 15) h = 4095;
      else if (roll < 30) h = $urandom_range(0, 4095);
      else h = $urandom_range(1, 100);
    end
    set_config(count, ox, oy, w, h);
    n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
    lo_x = clamp_coord(ox - 2 * w - 8);
    hi_x = clamp_coord(ox + GRID_SIDE * w + 2 * w + 8);
    lo_y = clamp_coord(oy - 2 * h - 8);
    hi_y = clamp_coord(oy + GRID_SIDE * h + 2 * h + 8);
    // every slot in use is written before any classify reads it
    for (int s = 0; s < n; s++) write_vertex(s, rand_coord(lo_x, hi_x), rand_coord(lo_y, hi_y));
    burst = $urandom_range(20, 60);
    repeat (burst) begin
      if ($urandom_range(0, 3) != 0)
        classify_at($urandom_range(0, GRID_SIDE - 1), $urandom_range(0, GRID_SIDE - 1));
      else
        write_vertex($urandom_range(0, MAX_VERTICES - 1), rand_coord(lo_x, hi_x),
                     rand_coord(lo_y, hi_y));
    end
  endtask

  initial begin : stimulus
    int phase_no;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.command = CMD_WRITE;
    req.vertex_slot = '0;
    req.vertex_x = '0;
    req.vertex_y = '0;
    req.cell_row = '0;
    req.cell_col = '0;
    items_sent = 0;
    send_quiet = 0;
    rsp_quiet = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty polygon under the reset geometry
    classify_at(0, 0);
    classify_at(GRID_SIDE - 1, GRID_SIDE - 1);
    // rectangle around the first ten rows and columns, plus coordinate extremes in the top slots
    write_vertex(0, -5, -5);
    write_vertex(1, 205, -5);
    write_vertex(2, 205, 125);
    write_vertex(3, -5, 125);
    write_vertex(MAX_VERTICES - 1, -32768, 32767);
    write_vertex(MAX_VERTICES - 2, 32767, -32768);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(4));
    classify_at(0, 0);
    classify_at(9, 9);
    classify_at(10, 5);
    classify_at(5, 10);
    classify_at(GRID_SIDE - 1, GRID_SIDE - 1);
    // one vertex never toggles and two toggle in pairs, so every corner stays outside
    wait_idle();
    write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(1));
    classify_at(0, 0);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(2));
    classify_at(0, 0);
    // zero cell size: all four corners on the origin
    set_config(4, 50, 50, 0, 0);
    classify_at(7, 7);
    set_config(4, -100, 30, 0, 0);
    classify_at(0, 0);

    phase_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      run_phase(phase_no);
      phase_no++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/gcpc_pkg.sv
rtl/core/gcpc_if.sv
rtl/core/grid_cell_polygon_classifier.sv
verif/cell_class_monitor.sv
verif/testbench.sv
